// ----- hw/rtl/isotp_receive_reassembler_unit_assert.svh -----
// Assertion macros shared by the checker files of the reassembler.
// Each macro expands to one labeled concurrent assertion on clk_i.
`ifndef ISOTP_RECEIVE_REASSEMBLER_UNIT_ASSERT_SVH
`define ISOTP_RECEIVE_REASSEMBLER_UNIT_ASSERT_SVH

// Checked outside reset only.
`define ISOTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define ISOTP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/isotp_pkg.sv -----
// ----------------------------------------------------------------------------
// isotp_pkg
// Types, codes and constants shared by the ISO-TP receive reassembler.
// ----------------------------------------------------------------------------
package isotp_pkg;

  // Geometry
  localparam int unsigned NUM_ROWS    = 16;
  localparam int unsigned ROW_BYTES   = 7;
  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned ROW_LEN_W   = 3;
  localparam int unsigned REMAIN_W    = 12;
  localparam int unsigned REQ_ID_W    = 29;
  localparam int unsigned CFG_DATA_W  = 29;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned PENDING_LEN = 3;

  // Protocol constants
  localparam logic [7:0]  NEG_RESP_SID   = 8'h7F;
  localparam logic [7:0]  PEND_SID       = 8'h22;
  localparam logic [7:0]  PEND_NRC       = 8'h78;
  localparam logic [31:0] VIN_REPLY_ID   = 32'h0000_07EA;
  localparam logic [28:0] MAX_FILTER_ID  = 29'd4095;
  localparam logic [29:0] RESP_ID_OFFSET = 30'd8;
  localparam logic [3:0]  MAX_DLC        = 4'd8;

  // Protocol control nibble
  localparam logic [3:0] PCI_SINGLE = 4'h0;
  localparam logic [3:0] PCI_FIRST  = 4'h1;
  localparam logic [3:0] PCI_CONSEC = 4'h2;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    ST_EMPTY    = 3'd0,
    ST_SHORT    = 3'd1,
    ST_FILTERED = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_STORED   = 3'd4,
    ST_COMPLETE = 3'd5,
    ST_PENDING  = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_CHAR = 2'd0,
    CFG_MIN_LEN    = 2'd1,
    CFG_REQ_ID     = 2'd2,
    CFG_VIN_MODE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RESULT,
    S_SCAN,
    S_PEND_CHK,
    S_EMIT_ISSUE,
    S_EMIT_OUT
  } state_e;

  // One stored row: length and zero-padded payload
  typedef struct packed {
    logic [ROW_LEN_W-1:0]  len;
    byte_t [ROW_BYTES-1:0] bytes;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
    logic res_load;
    logic pend_load;
    logic walk_load;
    logic head_clear;
    logic scan_issue;
    logic absorb;
    logic emit_issue;
    logic emit_sel;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ev_merge;
    logic ev_scan;
    logic walk_empty;
    logic rd_vld;
    logic head_pending;
    logic emit_last;
  } dp_status_t;

endpackage

// ----- hw/rtl/isotp_frame_if.sv -----
// ----------------------------------------------------------------------------
// isotp_frame_if
// Received CAN frame channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface isotp_frame_if;
  import isotp_pkg::*;

  logic        valid;
  logic        ready;
  logic [31:0] frame_id;
  logic [3:0]  frame_length;
  byte_t       data0;
  byte_t       data1;
  byte_t       data2;
  byte_t       data3;
  byte_t       data4;
  byte_t       data5;
  byte_t       data6;
  byte_t       data7;

  modport source (
    output valid, frame_id, frame_length,
    output data0, data1, data2, data3, data4, data5, data6, data7,
    input  ready
  );

  modport sink (
    input  valid, frame_id, frame_length,
    input  data0, data1, data2, data3, data4, data5, data6, data7,
    output ready
  );
endinterface

// ----- hw/rtl/isotp_result_if.sv -----
// ----------------------------------------------------------------------------
// isotp_result_if
// Reassembly result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface isotp_result_if;
  import isotp_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] byte_count;
  byte_t      out0;
  byte_t      out1;
  byte_t      out2;
  byte_t      out3;
  byte_t      out4;
  byte_t      out5;
  byte_t      out6;
  logic       last;

  modport source (
    output valid, status, byte_count,
    output out0, out1, out2, out3, out4, out5, out6, last,
    input  ready
  );

  modport sink (
    input  valid, status, byte_count,
    input  out0, out1, out2, out3, out4, out5, out6, last,
    output ready
  );
endinterface

// ----- hw/rtl/isotp_ram.sv -----
// ----------------------------------------------------------------------------
// isotp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module isotp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hw/rtl/isotp_ctrl.sv -----
// ----------------------------------------------------------------------------
// isotp_ctrl
// Sequencer: frame capture, evaluation, single results, pending scan and row emission.
// ----------------------------------------------------------------------------
module isotp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  isotp_pkg::dp_status_t  status_i,
  output isotp_pkg::ctrl_cmd_t   cmd_o
);
  import isotp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        priority if (!status_i.ev_merge) state_d = S_RESULT;
        else if (status_i.ev_scan)       state_d = S_SCAN;
        else                             state_d = S_EMIT_ISSUE;
      end
      S_RESULT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (status_i.walk_empty && !status_i.rd_vld) state_d = S_PEND_CHK;
      end
      S_PEND_CHK: begin
        state_d = status_i.head_pending ? S_RESULT : S_EMIT_ISSUE;
      end
      S_EMIT_ISSUE: begin
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_ready_i && status_i.emit_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EVAL: begin
        cmd_o.commit     = 1'b1;
        cmd_o.res_load   = !status_i.ev_merge;
        cmd_o.walk_load  = status_i.ev_merge;
        cmd_o.head_clear = status_i.ev_merge;
      end
      S_RESULT: begin
        out_valid_o = 1'b1;
      end
      S_SCAN: begin
        cmd_o.scan_issue = !status_i.walk_empty;
        cmd_o.absorb     = status_i.rd_vld;
      end
      S_PEND_CHK: begin
        cmd_o.pend_load = status_i.head_pending;
        cmd_o.walk_load = !status_i.head_pending;
      end
      S_EMIT_ISSUE: begin
        cmd_o.emit_issue = 1'b1;
      end
      S_EMIT_OUT: begin
        out_valid_o      = 1'b1;
        cmd_o.emit_sel   = 1'b1;
        cmd_o.emit_issue = out_ready_i && !status_i.emit_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end
endmodule

// ----- hw/rtl/isotp_dpath.sv -----
// ----------------------------------------------------------------------------
// isotp_dpath
// Frame decode, filtering, row store, remaining count and result registers.
// ----------------------------------------------------------------------------
module isotp_dpath #(
  parameter int unsigned RowCount = isotp_pkg::NUM_ROWS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [isotp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [isotp_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // frame payload
  input  logic [31:0]                            frame_id_i,
  input  logic [3:0]                             frame_len_i,
  input  isotp_pkg::byte_t [isotp_pkg::FRAME_BYTES-1:0] frame_data_i,
  // control
  input  isotp_pkg::ctrl_cmd_t                   cmd_i,
  output isotp_pkg::dp_status_t                  status_o,
  // result payload
  output isotp_pkg::status_e                     res_status_o,
  output logic [isotp_pkg::ROW_LEN_W-1:0]        res_count_o,
  output isotp_pkg::byte_t [isotp_pkg::ROW_BYTES-1:0] res_bytes_o,
  output logic                                   res_last_o
);
  import isotp_pkg::*;

  localparam int unsigned IdxW   = $clog2(RowCount);
  localparam int unsigned TotalW = $clog2(RowCount * ROW_BYTES + 1);

  // Configuration registers
  logic                sce_q;
  logic [3:0]          min_len_q;
  logic [REQ_ID_W-1:0] req_id_q;
  logic                vin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sce_q     <= 1'b0;
      min_len_q <= '0;
      req_id_q  <= '0;
      vin_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_CHAR: sce_q     <= cfg_wdata_i[0];
        CFG_MIN_LEN:    min_len_q <= cfg_wdata_i[3:0];
        CFG_REQ_ID:     req_id_q  <= cfg_wdata_i[REQ_ID_W-1:0];
        CFG_VIN_MODE:   vin_q     <= cfg_wdata_i[0];
      endcase
    end
  end

  // Captured frame
  logic [31:0]                 frame_id_q;
  logic [3:0]                  frame_len_q;
  byte_t [FRAME_BYTES-1:0]     d_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      frame_id_q  <= frame_id_i;
      frame_len_q <= frame_len_i;
      d_q         <= frame_data_i;
    end
  end

  // Reassembly state
  logic [RowCount-1:0]  present_q, present_d;
  logic [ROW_LEN_W-1:0] len_q [RowCount];
  logic [REMAIN_W-1:0]  br_q;
  logic [TotalW-1:0]    total_q;

  // Decode signals
  logic [3:0]            len_c, off_w, flen;
  logic [7:0]            pci, b1, b2, b3;
  logic                  neg, allow, match_resp, match_req, filt, short_frm;
  logic [29:0]           rid_p8;
  logic [2:0]            sf_avail, sf_size, ff_cnt, st_cnt, st_start;
  logic                  sf_pend, is_ff;
  byte_t [ROW_BYTES-1:0] sf_bytes, st_bytes;
  logic [IdxW-1:0]       st_idx;
  logic [REMAIN_W-1:0]   br_base, br_next;
  logic [ROW_LEN_W-1:0]  old_len;
  logic [TotalW-1:0]     total_next;
  logic [RowCount-1:0]   present_new;
  status_e               ev_status;
  logic [2:0]            ev_count;
  byte_t [ROW_BYTES-1:0] ev_bytes;
  logic                  ev_store, ev_single;

  // Header fields, filter and payload sizes
  always_comb begin
    logic [2:0] sidx;
    logic [2:0] tidx;
    len_c  = (frame_len_q > MAX_DLC) ? MAX_DLC : frame_len_q;
    off_w  = {3'b000, sce_q};
    pci    = sce_q ? d_q[1] : d_q[0];
    b1     = sce_q ? d_q[2] : d_q[1];
    b2     = sce_q ? d_q[3] : d_q[2];
    b3     = sce_q ? d_q[4] : d_q[3];
    flen   = (len_c > off_w) ? (len_c - off_w) : 4'd0;

    short_frm  = (min_len_q != 4'd0) && (len_c < min_len_q);
    neg        = (pci[7:4] == PCI_SINGLE) && (len_c > (off_w + 4'd2)) &&
                 (b1 == NEG_RESP_SID);
    rid_p8     = {1'b0, req_id_q} + RESP_ID_OFFSET;
    match_resp = (frame_id_q == {2'b00, rid_p8});
    match_req  = (frame_id_q == {3'b000, req_id_q});
    allow      = vin_q && (frame_id_q == VIN_REPLY_ID);
    filt       = (req_id_q <= MAX_FILTER_ID) && !match_resp &&
                 !(match_req && neg) && !allow;

    // single frame size clamped to the bytes carried
    sf_avail = (flen > 4'd1) ? 3'(flen - 4'd1) : 3'd0;
    sf_size  = ({1'b0, sf_avail} < pci[3:0]) ? sf_avail : pci[2:0];
    sf_pend  = (sf_size == 3'(PENDING_LEN)) && (b1 == NEG_RESP_SID) &&
               (b2 == PEND_SID) && (b3 == PEND_NRC);

    // first or consecutive frame row contents
    is_ff    = (pci[7:4] == PCI_FIRST);
    ff_cnt   = (flen > 4'd2) ? 3'(flen - 4'd2) : 3'd0;
    st_cnt   = is_ff ? ff_cnt : sf_avail;
    st_start = (is_ff ? 3'd2 : 3'd1) + {2'b00, sce_q};
    st_idx   = is_ff ? '0 : pci[IdxW-1:0];

    for (int j = 0; j < ROW_BYTES; j++) begin
      sidx        = 3'(j) + 3'd1 + {2'b00, sce_q};
      tidx        = st_start + 3'(j);
      sf_bytes[j] = (3'(j) < sf_size) ? d_q[sidx] : 8'h00;
      st_bytes[j] = (3'(j) < st_cnt) ? d_q[tidx] : 8'h00;
    end
  end

  // Remaining count, merged length and presence mask after a store
  always_comb begin
    br_base    = is_ff ? {pci[3:0], b1} : br_q;
    br_next    = (br_base > REMAIN_W'(st_cnt)) ? (br_base - REMAIN_W'(st_cnt)) : '0;
    old_len    = present_q[st_idx] ? len_q[st_idx] : '0;
    total_next = is_ff ? TotalW'(st_cnt)
                       : (total_q - TotalW'(old_len) + TotalW'(st_cnt));
    present_new         = is_ff ? '0 : present_q;
    present_new[st_idx] = 1'b1;
  end

  // Classify the frame; order decides
  always_comb begin
    ev_status = ST_STORED;
    ev_count  = '0;
    ev_bytes  = '0;
    ev_store  = 1'b0;
    ev_single = 1'b0;
    priority if (frame_id_q == 32'd0) begin
      ev_status = ST_EMPTY;
    end else if (short_frm) begin
      ev_status = ST_SHORT;
    end else if (filt) begin
      ev_status = ST_FILTERED;
    end else begin
      unique case (pci[7:4])
        PCI_SINGLE: begin
          ev_single = 1'b1;
          if (sf_pend) begin
            ev_status = ST_PENDING;
          end else begin
            ev_status = ST_COMPLETE;
            ev_count  = sf_size;
            ev_bytes  = sf_bytes;
          end
        end
        PCI_FIRST, PCI_CONSEC: begin
          ev_store  = 1'b1;
          ev_status = ST_STORED;
        end
        default: begin
          ev_status = ST_UNKNOWN;
        end
      endcase
    end
  end

  assign present_d = (cmd_i.commit && ev_store) ? present_new : present_q;

  // Commit state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      br_q      <= '0;
      total_q   <= '0;
      for (int i = 0; i < RowCount; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      present_q <= present_d;
      if (cmd_i.commit && ev_single) begin
        br_q <= '0;
      end
      if (cmd_i.commit && ev_store) begin
        len_q[st_idx] <= st_cnt;
        br_q          <= br_next;
        total_q       <= total_next;
      end
    end
  end

  // Row store
  row_t            wr_row, rd_row;
  logic [ROW_W-1:0] rdata;
  logic [IdxW-1:0] walk_idx;

  assign wr_row.len   = st_cnt;
  assign wr_row.bytes = st_bytes;

  isotp_ram #(
    .Width (ROW_W),
    .Depth (RowCount)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && ev_store),
    .waddr_i (st_idx),
    .wdata_i (wr_row),
    .re_i    (cmd_i.scan_issue || cmd_i.emit_issue),
    .raddr_i (walk_idx),
    .rdata_o (rdata)
  );

  assign rd_row = row_t'(rdata);

  // Walk the present rows lowest first
  logic [RowCount-1:0] walk_q, walk_rest;
  logic                rd_vld_q, emit_last_q;

  always_comb begin
    walk_idx = '0;
    for (int i = RowCount - 1; i >= 0; i--) begin
      if (walk_q[i]) walk_idx = IdxW'(i);
    end
    walk_rest           = walk_q;
    walk_rest[walk_idx] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q      <= '0;
      rd_vld_q    <= 1'b0;
      emit_last_q <= 1'b0;
    end else begin
      if (cmd_i.walk_load) begin
        walk_q <= present_d;
      end else if (cmd_i.scan_issue || cmd_i.emit_issue) begin
        walk_q <= walk_rest;
      end
      rd_vld_q <= cmd_i.scan_issue;
      if (cmd_i.emit_issue) begin
        emit_last_q <= (walk_rest == '0);
      end
    end
  end

  // Collect the first bytes of the merged reply for the pending test
  byte_t [PENDING_LEN-1:0] head_q, head_d;
  logic [1:0]              head_cnt_q, head_cnt_d;

  always_comb begin
    logic [2:0] pos;
    logic [3:0] sum;
    head_d = head_q;
    for (int j = 0; j < PENDING_LEN; j++) begin
      pos = {1'b0, head_cnt_q} + 3'(j);
      if ((3'(j) < rd_row.len) && (pos < 3'(PENDING_LEN))) begin
        head_d[pos[1:0]] = rd_row.bytes[j];
      end
    end
    sum        = {2'b00, head_cnt_q} + {1'b0, rd_row.len};
    head_cnt_d = (sum > 4'(PENDING_LEN)) ? 2'(PENDING_LEN) : sum[1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_cnt_q <= '0;
    end else if (cmd_i.head_clear) begin
      head_cnt_q <= '0;
    end else if (cmd_i.absorb) begin
      head_cnt_q <= head_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb) begin
      head_q <= head_d;
    end
  end

  // Single-result register
  status_e               res_status_q;
  logic [2:0]            res_count_q;
  byte_t [ROW_BYTES-1:0] res_bytes_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= ev_status;
      res_count_q  <= ev_count;
      res_bytes_q  <= ev_bytes;
    end else if (cmd_i.pend_load) begin
      res_status_q <= ST_PENDING;
      res_count_q  <= '0;
      res_bytes_q  <= '0;
    end
  end

  // Result select: row store read data during emission
  assign res_status_o = cmd_i.emit_sel ? ST_COMPLETE  : res_status_q;
  assign res_count_o  = cmd_i.emit_sel ? rd_row.len   : res_count_q;
  assign res_bytes_o  = cmd_i.emit_sel ? rd_row.bytes : res_bytes_q;
  assign res_last_o   = cmd_i.emit_sel ? emit_last_q  : 1'b1;

  // Status to the controller
  assign status_o.ev_merge     = ev_store && (br_next == '0);
  assign status_o.ev_scan      = (total_next == TotalW'(PENDING_LEN));
  assign status_o.walk_empty   = (walk_q == '0);
  assign status_o.rd_vld       = rd_vld_q;
  assign status_o.head_pending = (head_cnt_q == 2'(PENDING_LEN)) &&
                                 (head_q[0] == NEG_RESP_SID) &&
                                 (head_q[1] == PEND_SID) &&
                                 (head_q[2] == PEND_NRC);
  assign status_o.emit_last    = emit_last_q;
endmodule

// ----- hw/rtl/isotp_receive_reassembler_unit.sv -----
// ----------------------------------------------------------------------------
// isotp_receive_reassembler_unit
// ISO-TP receive reassembly of CAN frames into single and multi-row results.
// ----------------------------------------------------------------------------
// The unit takes one received CAN frame at a time and accepts the next frame
// only once every result of the current one has been transferred. A rejected,
// single or stored frame passes through capture, evaluate and result, plus
// any output stall. A frame that completes a message passes through capture,
// evaluate and first row read, then emits one row per cycle while the output
// is not stalled, up to sixteen rows, paced by the registered read port of
// the row store. When the merged reply is exactly three bytes long, a scan
// that reads every present row, followed by a check step, first tests it for
// a response-pending reply.
// The row store needs no clearing pass after reset.
// Configuration writes take effect at once and are meant for idle periods.
module isotp_receive_reassembler_unit #(
  parameter int unsigned RowCount = isotp_pkg::NUM_ROWS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [isotp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [isotp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  isotp_frame_if.sink                      frame_i,
  isotp_result_if.source                   result_o
);
  import isotp_pkg::*;

  ctrl_cmd_t             cmd;
  dp_status_t            dp_status;
  status_e               res_status;
  logic [ROW_LEN_W-1:0]  res_count;
  byte_t [ROW_BYTES-1:0] res_bytes;
  logic                  res_last;
  byte_t [FRAME_BYTES-1:0] frame_data;
  logic                  in_ready, out_valid;

  assign frame_data = {frame_i.data7, frame_i.data6, frame_i.data5, frame_i.data4,
                       frame_i.data3, frame_i.data2, frame_i.data1, frame_i.data0};

  isotp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frame_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  isotp_dpath #(
    .RowCount (RowCount)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .frame_id_i   (frame_i.frame_id),
    .frame_len_i  (frame_i.frame_length),
    .frame_data_i (frame_data),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .res_status_o (res_status),
    .res_count_o  (res_count),
    .res_bytes_o  (res_bytes),
    .res_last_o   (res_last)
  );

  // Drive the channels
  assign frame_i.ready       = in_ready;
  assign result_o.valid      = out_valid;
  assign result_o.status     = res_status;
  assign result_o.byte_count = res_count;
  assign result_o.out0       = res_bytes[0];
  assign result_o.out1       = res_bytes[1];
  assign result_o.out2       = res_bytes[2];
  assign result_o.out3       = res_bytes[3];
  assign result_o.out4       = res_bytes[4];
  assign result_o.out5       = res_bytes[5];
  assign result_o.out6       = res_bytes[6];
  assign result_o.last       = res_last;
endmodule

// ----- hw/rtl/isotp_receive_reassembler_unit_checker.sv -----
// ----------------------------------------------------------------------------
// isotp_receive_reassembler_unit_checker
// Port-level assertions for the reassembler, bound to the top level.
// ----------------------------------------------------------------------------
`include "isotp_receive_reassembler_unit_assert.svh"

module isotp_receive_reassembler_unit_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_status_i,
  input logic [2:0] out_count_i,
  input logic [7:0] out0_i,
  input logic [7:0] out6_i,
  input logic       out_last_i
);
  import isotp_pkg::*;

  // No frame is taken while a result waits for transfer
  `ISOTP_ASSERT_ALWAYS(a_no_accept_with_result, out_valid_i |-> !in_ready_i, "frame accepted while result pending")

  // An accepted frame is evaluated before another one is taken
  `ISOTP_ASSERT(a_one_frame_at_a_time, (in_valid_i && in_ready_i) |=> !in_ready_i, "back-to-back frame accepted")

  // Every result other than a complete one is a lone empty result
  `ISOTP_ASSERT(a_status_only_last, (out_valid_i && (out_status_i != ST_COMPLETE)) |-> (out_last_i && (out_count_i == 3'd0)), "status result not last or not empty")

  // With a count of zero, the first byte is zero
  `ISOTP_ASSERT(a_empty_bytes_zero, (out_valid_i && (out_count_i == 3'd0)) |-> (out0_i == 8'h00), "byte beyond count not zero")

  // Short results leave the top byte clear
  `ISOTP_ASSERT(a_top_byte_zero, (out_valid_i && out_ready_i && (out_count_i != 3'd7)) |-> (out6_i == 8'h00), "top byte set on short result")
endmodule

bind isotp_receive_reassembler_unit isotp_receive_reassembler_unit_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (frame_i.valid),
  .in_ready_i   (frame_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_status_i (result_o.status),
  .out_count_i  (result_o.byte_count),
  .out0_i       (result_o.out0),
  .out6_i       (result_o.out6),
  .out_last_i   (result_o.last)
);

// ----- tb/tb_isotp_receive_reassembler_unit.sv -----
// ----------------------------------------------------------------------------
// tb_isotp_receive_reassembler_unit
// Self-checking bench for the ISO-TP receive reassembler. CAN frames go in over
// the frame channel while a behavioral copy of the reassembly predicts every
// result row. A checker compares each transferred result with the oldest
// prediction. Directed cases run first, then random message traffic under
// several register settings, a long output stall and a back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_isotp_receive_reassembler_unit;
  import isotp_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam int unsigned STALL_CYCLES   = 400;
  localparam int unsigned MISMATCH_SHOWN = 10;
  localparam int unsigned IDLE_PERCENT   = 28;
  localparam int unsigned SETTLE_CYCLES  = 40;

  // Frame types the block does not reassemble
  localparam logic [3:0] PCI_FLOW_CTRL = 4'h3;
  localparam logic [3:0] PCI_RESERVED  = 4'hF;

  localparam logic [31:0] DIAG_REQ  = 32'h0000_07E0;
  localparam logic [31:0] DIAG_RESP = 32'h0000_07E8;

  typedef struct {
    logic [31:0] id;
    logic [3:0]  len;
    byte_t       data [8];
  } can_frame_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  count;
    byte_t [6:0] bytes;
    logic        last;
  } reasm_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  isotp_frame_if  frame_bus ();
  isotp_result_if result_bus ();

  isotp_receive_reassembler_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_i     (frame_bus),
    .result_o    (result_bus)
  );

  // Register mirror
  logic        cfg_start_char;
  logic [3:0]  cfg_min_len;
  logic [28:0] cfg_req_id;
  logic        cfg_vin;

  // Reassembly state mirror
  byte_t [6:0] row_data [NUM_ROWS];
  logic [2:0]  row_len [NUM_ROWS];
  logic [15:0] row_valid;
  logic [12:0] pred_remaining;

  reasm_result_t predicted_results [$];
  int unsigned   mismatch_count;
  int unsigned   frames_sent;
  int unsigned   cycle_count;
  logic          steady_mode;
  logic          stall_request;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void push_predicted(status_e st, int unsigned cnt,
                                         byte_t [6:0] bytes, logic last);
    reasm_result_t r;
    r.status = st;
    r.count  = 3'(cnt);
    r.bytes  = bytes;
    r.last   = last;
    predicted_results.push_back(r);
  endfunction

  function automatic void store_row(int unsigned idx, can_frame_t f,
                                    int unsigned start, int unsigned cnt);
    byte_t [6:0] row;
    int unsigned i;
    row = '0;
    if (cnt > ROW_BYTES) cnt = ROW_BYTES;
    for (i = 0; i < cnt; i++) row[i] = f.data[(start + i) & 7];
    row_data[idx & 15] = row;
    row_len[idx & 15]  = 3'(cnt);
    row_valid[idx & 15] = 1'b1;
    pred_remaining = (pred_remaining > cnt) ? pred_remaining - 13'(cnt) : '0;
  endfunction

  // Walk the present rows; a lone three-byte 7F 22 78 reply collapses to pending
  function automatic void emit_rows();
    byte_t head [3];
    int unsigned total, i, j, k, rows;
    total = 0;
    for (i = 0; i < NUM_ROWS; i++) begin
      if (row_valid[i]) begin
        for (j = 0; j < row_len[i]; j++) begin
          if (total < 3) head[total] = row_data[i][j];
          total++;
        end
      end
    end
    if (total == PENDING_LEN && head[0] == NEG_RESP_SID && head[1] == PEND_SID &&
        head[2] == PEND_NRC) begin
      push_predicted(ST_PENDING, 0, '0, 1'b1);
    end else begin
      rows = $countones(row_valid);
      k = 0;
      for (i = 0; i < NUM_ROWS; i++) begin
        if (row_valid[i]) begin
          k++;
          push_predicted(ST_COMPLETE, row_len[i], row_data[i], k == rows);
        end
      end
    end
  endfunction

  function automatic void reassemble_frame(can_frame_t f);
    int unsigned len, off, flen, size, avail;
    byte_t       pci;
    byte_t [6:0] bytes;
    logic        neg, allow;
    int unsigned i;
    len = (f.len > MAX_DLC) ? 8 : f.len;
    off = cfg_start_char;
    pci = f.data[off];
    flen = (len > off) ? len - off : 0;
    neg = (pci[7:4] == 4'h0) && (len > off + 2) && (f.data[off + 1] == NEG_RESP_SID);
    allow = cfg_vin && (f.id == VIN_REPLY_ID);
    if (f.id == '0) begin
      push_predicted(ST_EMPTY, 0, '0, 1'b1);
    end else if (cfg_min_len != 0 && len < cfg_min_len) begin
      push_predicted(ST_SHORT, 0, '0, 1'b1);
    end else if (cfg_req_id <= MAX_FILTER_ID && f.id != 32'(cfg_req_id) + 32'd8 &&
                 !(f.id == 32'(cfg_req_id) && neg) && !allow) begin
      push_predicted(ST_FILTERED, 0, '0, 1'b1);
    end else begin
      case (pci[7:4])
        PCI_SINGLE: begin
          size = pci[3:0];
          avail = (flen > 1) ? flen - 1 : 0;
          if (size > avail) size = avail;
          pred_remaining = '0;
          if (size == PENDING_LEN && f.data[off + 1] == NEG_RESP_SID &&
              f.data[off + 2] == PEND_SID && f.data[off + 3] == PEND_NRC) begin
            push_predicted(ST_PENDING, 0, '0, 1'b1);
          end else begin
            bytes = '0;
            for (i = 0; i < size; i++) bytes[i] = f.data[off + 1 + i];
            push_predicted(ST_COMPLETE, size, bytes, 1'b1);
          end
        end
        PCI_FIRST: begin
          pred_remaining = {1'b0, pci[3:0], f.data[off + 1]};
          row_valid = '0;
          store_row(0, f, off + 2, (flen > 2) ? flen - 2 : 0);
          if (pred_remaining == 0) emit_rows();
          else push_predicted(ST_STORED, 0, '0, 1'b1);
        end
        PCI_CONSEC: begin
          store_row(pci[3:0], f, off + 1, (flen > 1) ? flen - 1 : 0);
          if (pred_remaining == 0) emit_rows();
          else push_predicted(ST_STORED, 0, '0, 1'b1);
        end
        default: begin
          push_predicted(ST_UNKNOWN, 0, '0, 1'b1);
        end
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    reasm_result_t seen, want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      seen.status = status_e'(result_bus.status);
      seen.count  = result_bus.byte_count;
      seen.bytes  = {result_bus.out6, result_bus.out5, result_bus.out4, result_bus.out3,
                     result_bus.out2, result_bus.out1, result_bus.out0};
      seen.last   = result_bus.last;
      if (predicted_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MISMATCH_SHOWN)
          $display("unexpected result: status %0d count %0d bytes %h last %0d",
                   seen.status, seen.count, seen.bytes, seen.last);
      end else begin
        want = predicted_results.pop_front();
        if (seen.status !== want.status || seen.count !== want.count ||
            seen.bytes !== want.bytes || seen.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MISMATCH_SHOWN)
            $display("result mismatch: expected status %0d count %0d bytes %h last %0d, %s",
                     want.status, want.count, want.bytes, want.last,
                     $sformatf("got status %0d count %0d bytes %h last %0d",
                               seen.status, seen.count, seen.bytes, seen.last));
        end
      end
    end
  end

  // Result receiver: random back-pressure, steady stretches and one long hold
  initial begin : result_receiver
    int unsigned held;
    held = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        result_bus.ready <= 1'b0;
        held++;
        if (held >= STALL_CYCLES) begin
          stall_request = 1'b0;
          held = 0;
        end
      end else if (steady_mode) begin
        result_bus.ready <= 1'b1;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("** isotp_receive_reassembler_unit: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Frame and register driving
  // --------------------------------------------------------------------------
  function automatic can_frame_t pack_frame(logic [31:0] id, byte_t body[$]);
    can_frame_t  f;
    int unsigned off, i, n;
    off = cfg_start_char;
    n = (body.size() > 8 - off) ? 8 - off : body.size();
    f.id = id;
    for (i = 0; i < 8; i++) f.data[i] = 8'($urandom);
    for (i = 0; i < n; i++) f.data[off + i] = body[i];
    f.len = 4'(off + n);
    return f;
  endfunction

  // Hold valid until the transfer, then record what the frame should produce
  task automatic send_frame(can_frame_t f);
    int unsigned gap;
    @(negedge clk_i);
    if (!steady_mode && $urandom_range(99) < IDLE_PERCENT) begin
      frame_bus.valid <= 1'b0;
      gap = $urandom_range(6, 1);
      repeat (gap) @(negedge clk_i);
    end
    frame_bus.valid        <= 1'b1;
    frame_bus.frame_id     <= f.id;
    frame_bus.frame_length <= f.len;
    frame_bus.data0        <= f.data[0];
    frame_bus.data1        <= f.data[1];
    frame_bus.data2        <= f.data[2];
    frame_bus.data3        <= f.data[3];
    frame_bus.data4        <= f.data[4];
    frame_bus.data5        <= f.data[5];
    frame_bus.data6        <= f.data[6];
    frame_bus.data7        <= f.data[7];
    do @(posedge clk_i); while (!frame_bus.ready);
    reassemble_frame(f);
    frames_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    frame_bus.valid <= 1'b0;
    while (predicted_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [28:0] value);
    wait_results_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_START_CHAR: cfg_start_char = value[0];
      CFG_MIN_LEN:    cfg_min_len = value[3:0];
      CFG_REQ_ID:     cfg_req_id = value;
      CFG_VIN_MODE:   cfg_vin = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(logic start_char, logic [3:0] min_len,
                                logic [28:0] req_id, logic vin);
    write_register(CFG_START_CHAR, 29'(start_char));
    write_register(CFG_MIN_LEN, 29'(min_len));
    write_register(CFG_REQ_ID, req_id);
    write_register(CFG_VIN_MODE, 29'(vin));
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------
  function automatic logic [31:0] answer_id();
    if (cfg_req_id > MAX_FILTER_ID)
      return ($urandom_range(3) == 0) ? DIAG_RESP : ($urandom | 32'h1);
    if (cfg_vin && $urandom_range(3) == 0) return VIN_REPLY_ID;
    return 32'(cfg_req_id) + 32'd8;
  endfunction

  task automatic send_noise();
    can_frame_t  f;
    int unsigned i;
    f.id = ($urandom_range(2) == 0) ? answer_id() : $urandom;
    if ($urandom_range(19) == 0) f.id = '0;
    f.len = 4'($urandom_range(15, 0));
    for (i = 0; i < 8; i++) f.data[i] = 8'($urandom);
    send_frame(f);
  endtask

  task automatic send_random_single();
    byte_t       body [$];
    logic [31:0] id;
    int unsigned off, size, pick;
    can_frame_t  f;
    off = cfg_start_char;
    id = answer_id();
    pick = $urandom_range(9);
    size = (pick == 0) ? $urandom_range(15, 0) : $urandom_range(7 - off, 0);
    if (pick == 1) size = PENDING_LEN;
    body = '{ {PCI_SINGLE, 4'(size)} };
    repeat (7 - off) body.push_back(8'($urandom));
    // Response-pending reply
    if (pick == 1) begin
      body[1] = NEG_RESP_SID;
      body[2] = PEND_SID;
      body[3] = PEND_NRC;
    end
    // Negative reply from the request ID itself
    if (pick == 2 && cfg_req_id <= MAX_FILTER_ID) begin
      id = 32'(cfg_req_id);
      body[1] = NEG_RESP_SID;
    end
    f = pack_frame(id, body);
    if ($urandom_range(1) == 0) f.len = 4'(off + 1 + ((size > 7 - off) ? 7 - off : size));
    send_frame(f);
  endtask

  task automatic send_random_multi();
    byte_t       body [$];
    logic [31:0] id;
    int unsigned off, total, seq, n;
    off = cfg_start_char;
    id = answer_id();
    case ($urandom_range(9))
      0:       total = $urandom_range(4095, 200);
      1, 2:    total = $urandom_range((6 - off) + 15 * (7 - off), 30);
      default: total = $urandom_range(40, 1);
    endcase
    body = '{ {PCI_FIRST, 4'(total >> 8)}, 8'(total) };
    repeat (6 - off) body.push_back(8'($urandom));
    send_frame(pack_frame(id, body));
    seq = 1;
    while (pred_remaining != 0 && seq <= 20) begin
      if ($urandom_range(24) == 0) send_noise();
      body = '{ {PCI_CONSEC, 4'(seq)} };
      n = ($urandom_range(7) == 0) ? $urandom_range(7 - off, 0) : 7 - off;
      repeat (n) body.push_back(8'($urandom));
      send_frame(pack_frame(id, body));
      seq++;
    end
  endtask

  task automatic run_random_traffic(int unsigned n_frames);
    int unsigned stop_at, pick;
    stop_at = frames_sent + n_frames;
    while (frames_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) send_random_multi();
      else if (pick < 75) send_random_single();
      else send_noise();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_rejections();
    can_frame_t f;
    apply_settings(1'b0, 4'd0, 29'(DIAG_REQ), 1'b0);
    send_frame(pack_frame(32'h0, '{ {PCI_SINGLE, 4'd2}, 8'h41, 8'h0D }));
    send_frame(pack_frame(DIAG_RESP + 32'd1, '{ {PCI_SINGLE, 4'd2}, 8'h41, 8'h0D }));
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_FLOW_CTRL, 4'h0}, 8'h00, 8'h00 }));
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_RESERVED, 4'hF}, 8'hFF }));
    // Minimum length at its top: three bytes rejected, a full frame passes
    write_register(CFG_MIN_LEN, 29'd8);
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_SINGLE, 4'd2}, 8'h41, 8'h0D }));
    f = pack_frame(DIAG_RESP, '{ {PCI_SINGLE, 4'd2}, 8'h41, 8'h0D });
    f.len = 4'd8;
    send_frame(f);
    write_register(CFG_MIN_LEN, 29'd0);
  endtask

  task automatic test_single_frames();
    can_frame_t f;
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_SINGLE, 4'd7}, 8'hFF, 8'h00, 8'hFF, 8'h80,
                                        8'h01, 8'hFE, 8'h7F }));
    // Size above the bytes carried is clamped
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_SINGLE, 4'hF}, 8'h11, 8'h22, 8'h33, 8'h44,
                                        8'h55, 8'h66, 8'h77 }));
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_SINGLE, 4'd3}, NEG_RESP_SID, PEND_SID,
                                        PEND_NRC }));
    // Length code above eight counts as eight
    f = pack_frame(DIAG_RESP, '{ {PCI_SINGLE, 4'd7}, 8'hA5, 8'h5A, 8'hC3, 8'h3C,
                                 8'h0F, 8'hF0, 8'h99 });
    f.len = 4'hF;
    send_frame(f);
    // Zero-length frame: nothing past the header
    f = pack_frame(DIAG_RESP, '{ {PCI_SINGLE, 4'd5} });
    f.len = 4'd0;
    send_frame(f);
  endtask

  task automatic test_multi_frame_messages();
    can_frame_t f;
    // Consecutive frame with no first frame: emitted at once
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_CONSEC, 4'd3}, 8'h01, 8'h02, 8'h03, 8'h04,
                                        8'h05, 8'h06, 8'h07 }));
    // First frame, then a consecutive frame that overshoots the count
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_FIRST, 4'h0}, 8'h0A, 8'h62, 8'hF1, 8'h90,
                                        8'h41, 8'h42, 8'h43 }));
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_CONSEC, 4'd1}, 8'h44, 8'h45, 8'h46, 8'h47,
                                        8'h48, 8'h49, 8'h4A }));
    // After completion a stray row merges with the kept rows
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_CONSEC, 4'd5}, 8'hE0, 8'hE1, 8'hE2 }));
    // Merged reply that is response pending
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_FIRST, 4'h0}, 8'h03, NEG_RESP_SID, PEND_SID,
                                        PEND_NRC }));
    // First frame shorter than its header
    f = pack_frame(DIAG_RESP, '{ {PCI_FIRST, 4'h0}, 8'h00 });
    f.len = 4'd1;
    send_frame(f);
    // Largest announced size, left open until the next single frame
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_FIRST, 4'hF}, 8'hFF, 8'h00, 8'hFF, 8'h00,
                                        8'hFF, 8'h00, 8'hFF }));
  endtask

  task automatic test_filter_modes();
    send_frame(pack_frame(DIAG_REQ, '{ {PCI_SINGLE, 4'd3}, NEG_RESP_SID, 8'h22, 8'h31 }));
    write_register(CFG_VIN_MODE, 29'd1);
    send_frame(pack_frame(VIN_REPLY_ID, '{ {PCI_SINGLE, 4'd2}, 8'h49, 8'h02 }));
    write_register(CFG_VIN_MODE, 29'd0);
    send_frame(pack_frame(VIN_REPLY_ID, '{ {PCI_SINGLE, 4'd2}, 8'h49, 8'h02 }));
    write_register(CFG_REQ_ID, 29'(MAX_FILTER_ID));
    send_frame(pack_frame(32'(MAX_FILTER_ID) + 32'd8, '{ {PCI_SINGLE, 4'd1}, 8'h7E }));
    write_register(CFG_REQ_ID, 29'd0);
    send_frame(pack_frame(32'd8, '{ {PCI_SINGLE, 4'd1}, 8'h50 }));
    // Filtering off: any ID, flag bits included
    write_register(CFG_REQ_ID, 29'h1FFF_FFFF);
    send_frame(pack_frame(32'hFFFF_FFFF, '{ {PCI_SINGLE, 4'd2}, 8'h41, 8'h05 }));
    // Extra address byte ahead of the protocol byte
    apply_settings(1'b1, 4'd0, 29'(DIAG_REQ), 1'b0);
    send_frame(pack_frame(DIAG_RESP, '{ {PCI_SINGLE, 4'd2}, 8'h41, 8'h0D }));
  endtask

  task automatic test_random_traffic();
    apply_settings(1'b0, 4'd0, 29'(DIAG_REQ), 1'b0);
    run_random_traffic(100);
    apply_settings(1'b1, 4'd2, 29'h6F1, 1'b1);
    run_random_traffic(80);
    apply_settings(1'b0, 4'd8, 29'(MAX_FILTER_ID), 1'b0);
    run_random_traffic(50);
    apply_settings(1'b1, 4'd0, 29'h1FFF_FFFF, 1'b0);
    run_random_traffic(50);
  endtask

  // Receiver holds off while frames keep coming, so the input backs up
  task automatic test_output_stall();
    apply_settings(1'b0, 4'd0, 29'(DIAG_REQ), 1'b1);
    stall_request = 1'b1;
    run_random_traffic(20);
  endtask

  task automatic test_back_to_back();
    steady_mode = 1'b1;
    run_random_traffic(30);
    wait_results_drained();
    steady_mode = 1'b0;
  endtask

  initial begin : stimulus
    int unsigned i;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_START_CHAR;
    cfg_wdata_i = '0;
    frame_bus.valid = 1'b0;
    frame_bus.frame_id = '0;
    frame_bus.frame_length = '0;
    frame_bus.data0 = '0;
    frame_bus.data1 = '0;
    frame_bus.data2 = '0;
    frame_bus.data3 = '0;
    frame_bus.data4 = '0;
    frame_bus.data5 = '0;
    frame_bus.data6 = '0;
    frame_bus.data7 = '0;
    cfg_start_char = 1'b0;
    cfg_min_len = '0;
    cfg_req_id = '0;
    cfg_vin = 1'b0;
    for (i = 0; i < NUM_ROWS; i++) begin
      row_data[i] = '0;
      row_len[i] = '0;
    end
    row_valid = '0;
    pred_remaining = '0;
    mismatch_count = 0;
    frames_sent = 0;
    steady_mode = 1'b0;
    stall_request = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_rejections();
    test_single_frames();
    test_multi_frame_messages();
    test_filter_modes();
    test_random_traffic();
    test_output_stall();
    test_back_to_back();

    // Let any stray result surface before judging
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("** isotp_receive_reassembler_unit: PASSED **");
    end else begin
      if (predicted_results.size() != 0)
        $display("%0d predicted results never arrived", predicted_results.size());
      $display("** isotp_receive_reassembler_unit: FAILED **");
    end
    $finish;
  end

endmodule
